### src/fmt_pkg.sv
// package for the float matmul tile: types, codes, float32 multiply and add helpers
// no dependencies
`timescale 1ns / 1ps
package fmt_pkg;
	localparam int TileDim = 8;
	localparam int Lanes = 8;
	localparam int Dim = (TileDim < Lanes) ? TileDim : Lanes;
	localparam logic [31:0] DefaultNan = 32'h7FC00000;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_DRAIN = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef logic [31:0] f32_t;
	typedef f32_t [Lanes-1:0] lane_vec_t;

	// row control handed down the chain of cells
	typedef struct packed {
		logic valid;
		cmd_t cmd;
		logic [2:0] row;
		logic [3:0] cols;
	} cell_ctl_t;

	function automatic logic is_nan(input f32_t x);
		is_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
	endfunction

	// round nearest even of a magnitude: mant has hidden bit at [26], low bits guard/round/sticky
	// exp is biased, may be <= 0 for subnormal results
	function automatic f32_t round_pack(input logic sign, input logic signed [10:0] exp_in,
			input logic [26:0] mant_in);
		logic signed [10:0] e;
		logic [26:0] m;
		logic [4:0] sh;
		logic sticky;
		logic [24:0] rnd;
		logic lsb, g, rs;
		f32_t r;
		e = exp_in;
		m = mant_in;
		if (e < 11'sd1) begin
			sh = ((11'sd1 - e) > 11'sd27) ? 5'd27 : 5'((11'sd1 - e));
			sticky = |(m & ((27'd1 << sh) - 27'd1));
			m = (m >> sh) | {26'd0, sticky};
			e = 11'sd0;
		end
		lsb = m[3];
		g = m[2];
		rs = |m[1:0];
		rnd = {1'b0, m[26:3]} + {24'd0, (g & (rs | lsb))};
		if (rnd[24]) begin
			rnd = rnd >> 1;
			e = e + 11'sd1;
		end else if (e == 11'sd0 && rnd[23]) begin
			e = 11'sd1;
		end
		if (e >= 11'sd255)
			r = {sign, 8'hFF, 23'd0};
		else
			r = {sign, e[7:0], rnd[22:0]};
		round_pack = r;
	endfunction

	function automatic f32_t fmul(input f32_t a, input f32_t b);
		logic s;
		logic [7:0] ea, eb;
		logic [23:0] ma, mb;
		logic [47:0] p;
		logic signed [10:0] e;
		logic [26:0] m;
		logic [5:0] lz;
		logic found;
		f32_t r;
		s = a[31] ^ b[31];
		ea = a[30:23];
		eb = b[30:23];
		ma = {(ea != 8'd0), a[22:0]};
		mb = {(eb != 8'd0), b[22:0]};
		p = ma * mb;
		lz = 6'd0;
		found = 1'b0;
		for (int k = 47; k >= 0; k--) begin
			if (!found && p[k]) begin
				found = 1'b1;
				lz = 6'(47 - k);
			end
		end
		if (is_nan(a) || is_nan(b))
			r = DefaultNan;
		else if (ea == 8'hFF || eb == 8'hFF) begin
			if ((ea == 8'hFF && b[30:0] == 31'd0) || (eb == 8'hFF && a[30:0] == 31'd0))
				r = DefaultNan;
			else
				r = {s, 8'hFF, 23'd0};
		end else if (p == 48'd0)
			r = {s, 31'd0};
		else begin
			p = p << lz;
			// value = p[47].p[46:0] * 2^(ea'+eb'-127-lz+1)
			e = 11'($signed({3'd0, (ea == 8'd0) ? 8'd1 : ea}))
				+ 11'($signed({3'd0, (eb == 8'd0) ? 8'd1 : eb})) - 11'sd126
				- 11'($signed({5'd0, lz}));
			m = {p[47:22], |p[21:0]};
			r = round_pack(s, e, m);
		end
		fmul = r;
	endfunction

	function automatic f32_t fadd(input f32_t a, input f32_t b);
		logic [7:0] ea, eb, eh, el;
		logic [26:0] mh, ml;
		logic sh_s, sl_s;
		logic [7:0] d;
		logic sticky;
		logic [27:0] sum;
		logic [4:0] lz;
		logic found;
		logic signed [10:0] e;
		logic [26:0] m;
		f32_t r;
		ea = a[30:23];
		eb = b[30:23];
		if (a[30:0] >= b[30:0]) begin
			eh = ea; el = eb; sh_s = a[31]; sl_s = b[31];
			mh = {(ea != 8'd0), a[22:0], 3'd0};
			ml = {(eb != 8'd0), b[22:0], 3'd0};
		end else begin
			eh = eb; el = ea; sh_s = b[31]; sl_s = a[31];
			mh = {(eb != 8'd0), b[22:0], 3'd0};
			ml = {(ea != 8'd0), a[22:0], 3'd0};
		end
		d = ((eh == 8'd0) ? 8'd1 : eh) - ((el == 8'd0) ? 8'd1 : el);
		if (d > 8'd27) begin
			sticky = |ml;
			ml = {26'd0, sticky};
		end else begin
			sticky = |(ml & ((27'd1 << d) - 27'd1));
			ml = (ml >> d) | {26'd0, sticky};
		end
		if (sh_s == sl_s)
			sum = {1'b0, mh} + {1'b0, ml};
		else
			sum = {1'b0, mh} - {1'b0, ml};
		e = 11'($signed({3'd0, (eh == 8'd0) ? 8'd1 : eh}));
		lz = 5'd0;
		found = 1'b0;
		for (int k = 26; k >= 0; k--) begin
			if (!found && sum[k]) begin
				found = 1'b1;
				lz = 5'(26 - k);
			end
		end
		if (is_nan(a) || is_nan(b))
			r = DefaultNan;
		else if (ea == 8'hFF && eb == 8'hFF)
			r = (a[31] == b[31]) ? a : DefaultNan;
		else if (ea == 8'hFF)
			r = a;
		else if (eb == 8'hFF)
			r = b;
		else if (sum == 28'd0)
			r = {(a[31] & b[31]), 31'd0};
		else if (sum[27]) begin
			m = {sum[27:2], |sum[1:0]};
			r = round_pack(sh_s, e + 11'sd1, m);
		end else begin
			// limit shift so exponent stays at least one (subnormal keeps e=1 form)
			if (11'($signed({6'd0, lz})) > e - 11'sd1)
				lz = 5'(e - 11'sd1);
			m = sum[26:0] << lz;
			e = e - 11'($signed({6'd0, lz}));
			if (!m[26])
				e = 11'sd0;
			// subnormal: pre-shift so the denormalizing shift in round_pack restores m
			r = round_pack(sh_s, e, (e == 11'sd0) ? (m << 1) : m);
			if (!m[26] && m[26:3] == 24'd0 && r[30:0] == 31'd0)
				r = {sh_s, 31'd0};
		end
		fadd = r;
	endfunction
endpackage

### src/fmt_if.sv
// valid/ready channel interfaces for the float matmul tile
// depends on nothing
`timescale 1ns / 1ps
interface fmt_in_if;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [2:0] row_index;
	logic [63:0] a_pair0, a_pair1, a_pair2, a_pair3;
	logic [63:0] b_pair0, b_pair1, b_pair2, b_pair3;
	modport source(output valid, command, row_index, a_pair0, a_pair1, a_pair2, a_pair3,
		b_pair0, b_pair1, b_pair2, b_pair3, input ready);
	modport sink(input valid, command, row_index, a_pair0, a_pair1, a_pair2, a_pair3,
		b_pair0, b_pair1, b_pair2, b_pair3, output ready);
endinterface

interface fmt_out_if;
	logic valid;
	logic ready;
	logic [2:0] out_row;
	logic [63:0] c_pair0, c_pair1, c_pair2, c_pair3;
	logic last_row;
	modport source(output valid, out_row, c_pair0, c_pair1, c_pair2, c_pair3, last_row,
		input ready);
	modport sink(input valid, out_row, c_pair0, c_pair1, c_pair2, c_pair3, last_row,
		output ready);
endinterface

### src/fmt_cell.sv
// one tile row cell: eight float32 accumulators with a two-stage multiply then add
// depends on fmt_pkg; passes the B row and control on to the next cell each cycle
`timescale 1ns / 1ps
module fmt_cell (
	input logic clk,
	input logic arst_n,
	input fmt_pkg::cell_ctl_t ctl,
	input fmt_pkg::lane_vec_t b_vec,
	input fmt_pkg::f32_t a_val,
	input logic [3:0] row_id,
	input logic [3:0] rows,
	output fmt_pkg::cell_ctl_t ctl_next,
	output fmt_pkg::lane_vec_t b_next,
	output fmt_pkg::lane_vec_t acc
);
	fmt_pkg::lane_vec_t acc_q;
	fmt_pkg::lane_vec_t prod_s1;
	logic upd_s1;
	logic [3:0] cols_s1;
	logic mine;

	assign mine = ctl.valid && (row_id < rows);
	assign acc = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_next <= '0;
			upd_s1 <= 1'b0;
		end else begin
			ctl_next <= ctl;
			upd_s1 <= mine && (ctl.cmd == fmt_pkg::CMD_UPDATE);
		end
	end

	always_ff @(posedge clk) begin
		b_next <= b_vec;
		cols_s1 <= ctl.cols;
		for (int j = 0; j < fmt_pkg::Lanes; j++)
			prod_s1[j] <= fmt_pkg::fmul(a_val, b_vec[j]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			if (ctl.valid && ctl.cmd == fmt_pkg::CMD_LOAD && {1'b0, ctl.row} == row_id)
				acc_q <= b_vec;
			else if (upd_s1) begin
				for (int j = 0; j < fmt_pkg::Lanes; j++)
					if (4'(j) < cols_s1)
						acc_q[j] <= fmt_pkg::fadd(acc_q[j], prod_s1[j]);
			end
		end
	end
endmodule

### src/float_matmul_tile_accumulate.sv
// top level of the float matmul tile: input control, chain of row cells, drain sequencer
// depends on fmt_pkg, fmt_if and fmt_cell
`timescale 1ns / 1ps
// Usage: items enter on in_ch (valid/ready). command load writes one C row,
// update adds the outer product a*b to the in-use part of the tile, drain
// emits rows 0..rows_in_use-1 on out_ch, one item per row, last_row marking
// the final one; unused columns read zero. The tile is not cleared by drain.
// Rows live in a chain of eight cells; an item walks down the chain one cell
// a cycle, each cell doing a registered multiply then add on its own row.
// Flow: one item is taken at a time; a load or update keeps ready low
// after it is taken (chain walk plus multiply and add stages) until its
// busy count runs out, and only then is the next item taken. A drain first
// moves to the drain state, which registers one row a cycle into out_ch
// while the receiver is not stalling. The output register holds a row
// while the receiver stalls; no rows are lost or repeated.
// Reset clears the tile to zero and sets rows_in_use and cols_in_use to 8.
// cfg writes must come only while the block is idle.
module float_matmul_tile_accumulate (
	input logic clk,
	input logic arst_n,
	fmt_in_if.sink in_ch,
	fmt_out_if.source out_ch,
	input logic cfg_we,
	input logic cfg_index,
	input logic [3:0] cfg_data
);
	localparam int N = fmt_pkg::Dim;
	localparam int BusyCycles = N + 3;

	typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_DRAIN} state_t;

	state_t state_q;
	logic [3:0] rows_q, cols_q, rows_c, cols_c;
	logic [4:0] cnt_q;
	logic [3:0] drow_q;
	fmt_pkg::cell_ctl_t ctl_chain [N+1];
	fmt_pkg::lane_vec_t b_chain [N+1];
	fmt_pkg::lane_vec_t acc_row [N];
	fmt_pkg::lane_vec_t a_q;
	fmt_pkg::lane_vec_t b_in, a_in;
	fmt_pkg::cell_ctl_t ctl_in;
	logic take;

	assign rows_c = (rows_q > 4'(N)) ? 4'(N) : rows_q;
	assign cols_c = (cols_q > 4'(N)) ? 4'(N) : cols_q;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign take = in_ch.valid && in_ch.ready;

	assign b_in = {in_ch.b_pair3, in_ch.b_pair2, in_ch.b_pair1, in_ch.b_pair0};
	assign a_in = {in_ch.a_pair3, in_ch.a_pair2, in_ch.a_pair1, in_ch.a_pair0};
	always_comb begin
		ctl_in.valid = take && (in_ch.command == fmt_pkg::CMD_LOAD
			|| in_ch.command == fmt_pkg::CMD_UPDATE);
		ctl_in.cmd = fmt_pkg::cmd_t'(in_ch.command);
		ctl_in.row = in_ch.row_index;
		ctl_in.cols = cols_c;
	end
	assign ctl_chain[0] = ctl_in;
	assign b_chain[0] = b_in;

	always_ff @(posedge clk) begin
		if (take)
			a_q <= a_in;
	end

	// cell k sees the item once it has passed the chain registers of the cells before it; cell 0 sees it at the input
	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_cell
			fmt_pkg::f32_t a_sel;
			assign a_sel = (k == 0) ? a_in[0] : a_q[k];
			fmt_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctl(ctl_chain[k]),
				.b_vec(b_chain[k]),
				.a_val(a_sel),
				.row_id(4'(k)),
				.rows(rows_c),
				.ctl_next(ctl_chain[k+1]),
				.b_next(b_chain[k+1]),
				.acc(acc_row[k])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rows_q <= 4'd8;
			cols_q <= 4'd8;
			cnt_q <= '0;
			drow_q <= '0;
			out_ch.valid <= 1'b0;
			out_ch.last_row <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index)
					cols_q <= cfg_data;
				else
					rows_q <= cfg_data;
			end
			// in drain a taken row is replaced by the next one below
			if (out_ch.valid && out_ch.ready && state_q != ST_DRAIN)
				out_ch.valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (in_ch.command == fmt_pkg::CMD_DRAIN) begin
							if (rows_c != 4'd0)
								state_q <= ST_DRAIN;
							drow_q <= '0;
						end else if (in_ch.command != fmt_pkg::CMD_NONE) begin
							state_q <= ST_BUSY;
							cnt_q <= 5'(BusyCycles);
						end
					end
				end
				ST_BUSY: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1)
						state_q <= ST_IDLE;
				end
				ST_DRAIN: begin
					if (!out_ch.valid || out_ch.ready) begin
						out_ch.valid <= 1'b1;
						out_ch.out_row <= drow_q[2:0];
						out_ch.last_row <= (drow_q + 4'd1 == rows_c);
						for (int j = 0; j < 2; j++) begin
							out_ch.c_pair0[32*j +: 32] <= (4'(j) < cols_c) ?
								acc_row[drow_q[2:0]][j] : 32'd0;
							out_ch.c_pair1[32*j +: 32] <= (4'(j + 2) < cols_c) ?
								acc_row[drow_q[2:0]][j+2] : 32'd0;
							out_ch.c_pair2[32*j +: 32] <= (4'(j + 4) < cols_c) ?
								acc_row[drow_q[2:0]][j+4] : 32'd0;
							out_ch.c_pair3[32*j +: 32] <= (4'(j + 6) < cols_c) ?
								acc_row[drow_q[2:0]][j+6] : 32'd0;
						end
						drow_q <= drow_q + 4'd1;
						if (drow_q + 4'd1 == rows_c)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
